@@ sv/sacl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg - shared types and constants
// Field widths, register codes, sequencer states and the control and status
// bundles between the sequencer and the way unit.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int WAY_W      = 3;   // way number field
    localparam int RANK_W     = 3;   // recency rank, 0 = oldest
    localparam int SET_OUT_W  = 10;  // set_index result field
    localparam int CNT_W      = 32;  // hit and miss counters
    localparam int IDX_BITS_W = 4;   // index_bits register
    localparam int WAY_BITS_W = 2;   // way_bits register
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int OUT_BITS   = 1 + WAY_W + SET_OUT_W + 2 * CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAY_BITS   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;  // new lookup, drop previous results
        logic             step;   // read data of one way is present
        logic [WAY_W-1:0] way;    // way of the read data
    } t_unit_ctl;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  sel;       // hit way, or least recent way
        logic [RANK_W-1:0] old_rank;  // rank of sel before the access
    } t_unit_res;

endpackage

@@ sv/sacl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram - simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/sacl_way_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_way_unit - per-way compare and rank unit
// Takes one way of a set per step: tag match and least-recent search.
// Also gives the new rank of a way for the write-back pass.
// ----------------------------------------------------------------------------
module sacl_way_unit #(
    parameter int TAG_W = 26
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sacl_pkg::t_unit_ctl         i_ctl,
    input  logic                        i_rd_valid,
    input  logic [TAG_W-1:0]            i_rd_tag,
    input  logic [sacl_pkg::RANK_W-1:0] i_rd_rank,
    input  logic [TAG_W-1:0]            i_tag,
    input  logic [sacl_pkg::WAY_W-1:0]  i_wmask,
    input  logic [sacl_pkg::WAY_W-1:0]  i_upd_way,
    input  logic [sacl_pkg::RANK_W-1:0] i_upd_rank,
    output sacl_pkg::t_unit_res         o_res,
    output logic [sacl_pkg::RANK_W-1:0] o_new_rank
);

    logic                        r_hit;
    logic [sacl_pkg::WAY_W-1:0]  r_hit_way;
    logic [sacl_pkg::RANK_W-1:0] r_hit_rank;
    logic [sacl_pkg::WAY_W-1:0]  r_min_way;
    logic [sacl_pkg::RANK_W:0]   r_min_rank;
    logic                        match;
    logic                        older;

    assign match = i_rd_valid && (i_rd_tag == i_tag);
    assign older = {1'b0, i_rd_rank} < r_min_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_min_rank <= '1;
        end else if (i_ctl.start) begin
            r_hit      <= 1'b0;
            r_min_rank <= '1;
        end else if (i_ctl.step) begin
            // keep the first matching way
            if (match && !r_hit) begin
                r_hit <= 1'b1;
            end
            // strict compare keeps the lowest way among equal ranks
            if (older) begin
                r_min_rank <= {1'b0, i_rd_rank};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && match && !r_hit) begin
            r_hit_way  <= i_ctl.way;
            r_hit_rank <= i_rd_rank;
        end
        if (i_ctl.step && older) begin
            r_min_way <= i_ctl.way;
        end
    end

    always_comb begin
        o_res.hit      = r_hit;
        o_res.sel      = r_hit ? r_hit_way : r_min_way;
        o_res.old_rank = r_hit ? r_hit_rank : r_min_rank[sacl_pkg::RANK_W-1:0];
    end

    // accessed way becomes the newest, the ones above it move down by one
    always_comb begin
        if (i_upd_way == o_res.sel) begin
            o_new_rank = sacl_pkg::RANK_W'(i_wmask);
        end else if (i_upd_rank > o_res.old_rank) begin
            o_new_rank = i_upd_rank - 1'b1;
        end else begin
            o_new_rank = i_upd_rank;
        end
    end

endmodule

@@ sv/set_assoc_cache_lru_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup - tag-only set-associative cache, true LRU
// Looks up one address per transfer, reports hit/miss, way, set and counts.
// ----------------------------------------------------------------------------
// Flow: W = ways in use. Each address is scanned, then its ranks and tag
//   are written back; a new address is taken only in idle, after that.
//   The scan reads one way a cycle through the single read port, with
//   registered read data; the write-back writes one way a cycle. A full
//   output register holds the block in done until the result is taken.
// Reset: synchronous, active low; clears counters and starts a clearing
//   pass over every entry. Each configuration write restarts that pass.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
    parameter int BLOCK_BYTES = 64,
    parameter int MAX_BLOCKS  = 1024,
    parameter int MAX_WAYS    = 8,
    parameter int ADDR_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // address stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((ADDR_BITS+7)/8)*8-1:0]      s_axis_tdata,  // address
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit, way, set_index, hit_count, miss_count
    output logic [sacl_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int ENT_BITS = $clog2(MAX_BLOCKS);
    localparam int WMAX     = $clog2(MAX_WAYS);
    localparam int TAG_W    = ADDR_BITS - OFF_BITS;
    localparam int WAY_W    = sacl_pkg::WAY_W;
    localparam int RANK_W   = sacl_pkg::RANK_W;
    localparam int CNT_W    = sacl_pkg::CNT_W;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    sacl_pkg::t_state                r_state, n_state;
    logic [sacl_pkg::IDX_BITS_W-1:0] r_index_bits;
    logic [sacl_pkg::WAY_BITS_W-1:0] r_way_bits;
    logic [ENT_BITS-1:0]             r_clr;
    logic [WAY_W-1:0]                r_w;
    logic                            r_iss_done;
    logic                            r_cv;
    logic [WAY_W-1:0]                r_cw;
    logic [RANK_W-1:0]               r_rank [2**WAY_W];
    logic [TAG_W-1:0]                r_tag;
    logic [ENT_BITS-1:0]             r_set;
    logic [CNT_W-1:0]                r_hits, n_hits;
    logic [CNT_W-1:0]                r_misses, n_misses;
    logic                            r_out_valid;
    logic [sacl_pkg::OUT_DATA_W-1:0] r_out_data;

    // ------------------------------------------------------------------
    // geometry: clamp ways first, then sets to the room left
    // ------------------------------------------------------------------
    logic [1:0]          eff_wb;
    logic [4:0]          room;
    logic [4:0]          eff_ib;
    logic [WAY_W-1:0]    wmask;
    logic [ENT_BITS:0]   one_sh;
    logic [ENT_BITS-1:0] set_mask;

    always_comb begin
        eff_wb   = (r_way_bits > 2'(WMAX)) ? 2'(WMAX) : r_way_bits;
        room     = 5'(ENT_BITS) - {3'b0, eff_wb};
        eff_ib   = ({1'b0, r_index_bits} > room) ? room : {1'b0, r_index_bits};
        wmask    = WAY_W'((4'd1 << eff_wb) - 4'd1);
        one_sh   = (ENT_BITS+1)'(1) << eff_ib;
        set_mask = ENT_BITS'(one_sh - (ENT_BITS+1)'(1));
    end

    // split the incoming address
    logic [ADDR_BITS-1:0] in_addr;
    logic [TAG_W-1:0]     in_blk;
    logic [TAG_W-1:0]     in_tag;
    logic [ENT_BITS-1:0]  in_set;

    always_comb begin
        in_addr = s_axis_tdata[ADDR_BITS-1:0];
        in_blk  = TAG_W'(in_addr >> OFF_BITS);
        in_tag  = in_blk >> eff_ib;
        in_set  = ENT_BITS'(in_blk) & set_mask;
    end

    // entry of (set, way) is (set << way_bits) | way
    logic [ENT_BITS-1:0] ent;
    assign ent = ENT_BITS'((((ENT_BITS+WAY_W)'(r_set)) << eff_wb)
                           | (ENT_BITS+WAY_W)'(r_w));

    // ------------------------------------------------------------------
    // stores and way unit
    // ------------------------------------------------------------------
    logic                tag_we;
    logic [ENT_BITS-1:0] tag_waddr;
    logic [TAG_W:0]      tag_wdata;   // {valid, tag}
    logic [TAG_W:0]      tag_rdata;
    logic                rank_we;
    logic [ENT_BITS-1:0] rank_waddr;
    logic [RANK_W-1:0]   rank_wdata;
    logic [RANK_W-1:0]   rank_rdata;
    logic [RANK_W-1:0]   new_rank;

    sacl_pkg::t_unit_ctl unit_ctl;
    sacl_pkg::t_unit_res unit_res;

    sacl_ram #(
        .WIDTH (TAG_W + 1),
        .DEPTH (MAX_BLOCKS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (ent),
        .o_rdata (tag_rdata)
    );

    sacl_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (rank_waddr),
        .i_wdata (rank_wdata),
        .i_raddr (ent),
        .o_rdata (rank_rdata)
    );

    sacl_way_unit #(
        .TAG_W (TAG_W)
    ) u_way_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (unit_ctl),
        .i_rd_valid (tag_rdata[TAG_W]),
        .i_rd_tag   (tag_rdata[TAG_W-1:0]),
        .i_rd_rank  (rank_rdata),
        .i_tag      (r_tag),
        .i_wmask    (wmask),
        .i_upd_way  (r_w),
        .i_upd_rank (r_rank[r_w]),
        .o_res      (unit_res),
        .o_new_rank (new_rank)
    );

    // ------------------------------------------------------------------
    // control decodes
    // ------------------------------------------------------------------
    logic cfg_wr;
    logic slot_free;
    logic scan_last;
    logic upd_last;
    logic load;

    always_comb begin
        case (i_cfg_index)
            sacl_pkg::CFG_INDEX_BITS: cfg_wr = i_cfg_we;
            sacl_pkg::CFG_WAY_BITS:   cfg_wr = i_cfg_we;
            default:                  cfg_wr = 1'b0;
        endcase
    end

    assign slot_free = !r_out_valid || m_axis_tready;
    assign scan_last = r_cv && (r_cw == wmask);
    assign upd_last  = (r_w == wmask);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sacl_pkg::ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = sacl_pkg::ST_SCAN;
                end
            end
            sacl_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = sacl_pkg::ST_UPDATE;
                end
            end
            sacl_pkg::ST_UPDATE: begin
                if (upd_last) begin
                    n_state = slot_free ? sacl_pkg::ST_IDLE : sacl_pkg::ST_DONE;
                end
            end
            sacl_pkg::ST_DONE: begin
                if (slot_free) begin
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            default: n_state = sacl_pkg::ST_CLEAR;
        endcase
        // a new geometry invalidates every entry
        if (cfg_wr) begin
            n_state = sacl_pkg::ST_CLEAR;
        end
    end

    // ------------------------------------------------------------------
    // state outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        tag_we        = 1'b0;
        tag_waddr     = ent;
        tag_wdata     = {1'b1, r_tag};
        rank_we       = 1'b0;
        rank_waddr    = ent;
        rank_wdata    = new_rank;
        unit_ctl      = '{start: 1'b0, step: 1'b0, way: r_cw};
        load          = 1'b0;
        case (r_state)
            sacl_pkg::ST_CLEAR: begin
                // invalidate, and rank each entry by its way number
                tag_we     = 1'b1;
                tag_waddr  = r_clr;
                tag_wdata  = '0;
                rank_we    = 1'b1;
                rank_waddr = r_clr;
                rank_wdata = RANK_W'(r_clr) & RANK_W'(wmask);
            end
            sacl_pkg::ST_IDLE: begin
                s_axis_tready  = 1'b1;
                unit_ctl.start = 1'b1;
            end
            sacl_pkg::ST_SCAN: begin
                unit_ctl.step = r_cv;
            end
            sacl_pkg::ST_UPDATE: begin
                rank_we = 1'b1;
                tag_we  = (r_w == unit_res.sel) && !unit_res.hit;
                load    = upd_last && slot_free;
            end
            sacl_pkg::ST_DONE: begin
                load = slot_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // saturating counters
    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (unit_res.hit) begin
            if (r_hits != '1) begin
                n_hits = r_hits + 1'b1;
            end
        end else begin
            if (r_misses != '1) begin
                n_misses = r_misses + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sacl_pkg::ST_CLEAR;
            r_index_bits <= 4'd2;
            r_way_bits   <= 2'd2;
            r_clr        <= '0;
            r_w          <= '0;
            r_iss_done   <= 1'b0;
            r_cv         <= 1'b0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we && (i_cfg_index == sacl_pkg::CFG_INDEX_BITS)) begin
                r_index_bits <= i_cfg_data[sacl_pkg::IDX_BITS_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == sacl_pkg::CFG_WAY_BITS)) begin
                r_way_bits <= i_cfg_data[sacl_pkg::WAY_BITS_W-1:0];
            end

            // clearing sweep, restarted by any configuration write
            if (cfg_wr) begin
                r_clr <= '0;
            end else if (r_state == sacl_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            case (r_state)
                sacl_pkg::ST_IDLE: begin
                    r_w        <= '0;
                    r_iss_done <= 1'b0;
                    r_cv       <= 1'b0;
                end
                sacl_pkg::ST_SCAN: begin
                    // issue one way read a cycle, read data follows in the next cycle
                    r_cv <= !r_iss_done;
                    if (!r_iss_done) begin
                        if (r_w == wmask) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_w <= r_w + 1'b1;
                        end
                    end
                    if (scan_last) begin
                        r_w <= '0;
                    end
                end
                sacl_pkg::ST_UPDATE: begin
                    r_w <= r_w + 1'b1;
                end
                default: begin
                    r_cv <= 1'b0;
                end
            endcase

            if (load) begin
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_tag <= in_tag;
            r_set <= in_set;
        end
        if (r_state == sacl_pkg::ST_SCAN) begin
            r_cw <= r_w;
            if (r_cv) begin
                r_rank[r_cw] <= rank_rdata;
            end
        end
        if (load) begin
            r_out_data <= sacl_pkg::OUT_DATA_W'({n_misses, n_hits,
                                                 sacl_pkg::SET_OUT_W'(r_set),
                                                 unit_res.sel, unit_res.hit});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ dv/set_assoc_cache_lru_lookup_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_checker - LRU lookup predictor and result check
// Watches the register port and both streams. Keeps its own valid, tag and
// recency state, predicts one result per address transfer and compares the
// result transfers against them in order.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_checker #(
    parameter int NUM_LINES    = 1024,
    parameter int OFFSET_W     = 6,
    parameter int REPORT_LIMIT = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_addr_valid,
    input  logic                            i_addr_ready,
    input  logic [31:0]                     i_addr_data,  // address
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    // hit, way, set_index, hit_count, miss_count
    input  logic [sacl_pkg::OUT_DATA_W-1:0] i_res_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_hits,
    output int                              o_misses
);

    localparam int LINE_BITS = $clog2(NUM_LINES);

    typedef struct packed {
        logic [sacl_pkg::CNT_W-1:0]     miss_count;
        logic [sacl_pkg::CNT_W-1:0]     hit_count;
        logic [sacl_pkg::SET_OUT_W-1:0] set_index;
        logic [sacl_pkg::WAY_W-1:0]     way;
        logic                           hit;
    } t_lookup_result;

    logic                             line_valid [NUM_LINES];
    logic [31:0]                      line_tag   [NUM_LINES];
    logic [sacl_pkg::RANK_W-1:0]      line_rank  [NUM_LINES];
    logic [sacl_pkg::IDX_BITS_W-1:0]  index_bits_reg;
    logic [sacl_pkg::WAY_BITS_W-1:0]  way_bits_reg;
    logic [sacl_pkg::CNT_W-1:0]       hits_total;
    logic [sacl_pkg::CNT_W-1:0]       misses_total;
    t_lookup_result                   awaited_results [$];

    // Invalidate every line and restart the recency order: way 0 oldest.
    function automatic void clear_lines();
        int unsigned wmask;
        wmask = (1 << way_bits_reg) - 1;
        for (int i = 0; i < NUM_LINES; i++) begin
            line_valid[i] = 1'b0;
            line_rank[i]  = sacl_pkg::RANK_W'(i & wmask);
        end
    endfunction

    function automatic t_lookup_result lookup_address(input logic [31:0] addr);
        int unsigned    wb, ib, ways, base, best, old_rank, w;
        logic [31:0]    set_no, tag;
        logic           found;
        logic [2:0]     sel;
        t_lookup_result r;
        wb     = way_bits_reg;
        ib     = (index_bits_reg > LINE_BITS - wb) ? LINE_BITS - wb : index_bits_reg;
        ways   = 1 << wb;
        set_no = (addr >> OFFSET_W) & ((32'd1 << ib) - 1);
        tag    = addr >> (OFFSET_W + ib);
        base   = set_no << wb;
        found  = 1'b0;
        sel    = '0;
        for (w = 0; w < ways; w++) begin
            if (!found && line_valid[base | w] && line_tag[base | w] == tag) begin
                found = 1'b1;
                sel   = 3'(w);
            end
        end
        // Miss: take the oldest way, lowest way number on a tie.
        if (!found) begin
            best = 8;
            for (w = 0; w < ways; w++) begin
                if (line_rank[base | w] < best) begin
                    best = line_rank[base | w];
                    sel  = 3'(w);
                end
            end
        end
        old_rank = line_rank[base | sel];
        for (w = 0; w < ways; w++) begin
            if (line_rank[base | w] > old_rank)
                line_rank[base | w] = line_rank[base | w] - 1'b1;
        end
        line_rank[base | sel] = sacl_pkg::RANK_W'(ways - 1);
        if (!found) begin
            line_valid[base | sel] = 1'b1;
            line_tag[base | sel]   = tag;
        end
        if (found) begin
            if (hits_total != '1)
                hits_total++;
        end else begin
            if (misses_total != '1)
                misses_total++;
        end
        r.hit        = found;
        r.way        = sel;
        r.set_index  = set_no[sacl_pkg::SET_OUT_W-1:0];
        r.hit_count  = hits_total;
        r.miss_count = misses_total;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_lookup_result got, want;
        if (!i_rst_n) begin
            index_bits_reg = 4'd2;
            way_bits_reg   = 2'd2;
            hits_total     = '0;
            misses_total   = '0;
            o_fail_count   = 0;
            o_hits         = 0;
            o_misses       = 0;
            clear_lines();
            awaited_results.delete();
        end else begin
            // A register write reshapes the cache and empties it; counts stay.
            if (i_cfg_we) begin
                if (i_cfg_index == sacl_pkg::CFG_INDEX_BITS)
                    index_bits_reg = i_cfg_data;
                else if (i_cfg_index == sacl_pkg::CFG_WAY_BITS)
                    way_bits_reg = i_cfg_data[sacl_pkg::WAY_BITS_W-1:0];
                clear_lines();
            end
            if (i_res_valid && i_res_ready) begin
                got = i_res_data[sacl_pkg::OUT_BITS-1:0];
                if (awaited_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: no lookup outstanding, expected nothing, got %h",
                                 $time, got);
                end else begin
                    // take the oldest prediction
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    compare_field("hit", want.hit, got.hit);
                    compare_field("way", want.way, got.way);
                    compare_field("set_index", want.set_index, got.set_index);
                    compare_field("hit_count", want.hit_count, got.hit_count);
                    compare_field("miss_count", want.miss_count, got.miss_count);
                    if (got.hit)
                        o_hits++;
                    else
                        o_misses++;
                end
            end
            if (i_addr_valid && i_addr_ready)
                awaited_results.insert(awaited_results.size(),
                                       lookup_address(i_addr_data));
        end
        o_pending = awaited_results.size();
    end

endmodule

@@ dv/set_assoc_cache_lru_lookup_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_test - stimulus and verdict for the LRU lookup
// Runs directed corner addresses at the reset geometry, then random address
// streams built from small tag and set pools over a series of geometries,
// with bursty input, a stalling result side and one long result hold-off.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_test;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int DRAIN_CYCLES     = 40;   // well past the worst lookup latency
    localparam int LONG_HOLD        = 300;
    localparam int RANDOM_PER_PHASE = 220;
    localparam int LINE_BITS        = 10;
    localparam int OFFSET_W         = 6;

    typedef enum {
        SINK_OPEN,
        SINK_HALF,
        SINK_SPARSE,
        SINK_MOSTLY
    } t_sink_style;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [31:0]                     s_axis_tdata;   // address
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // hit, way, set_index, hit_count, miss_count
    logic [sacl_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   pending;
    int   hits_seen;
    int   misses_seen;
    int   lookups_sent = 0;
    int   burst_left   = 0;
    int   geometries   = 1;
    int   cycle_count  = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;

    set_assoc_cache_lru_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    set_assoc_cache_lru_lookup_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_addr_valid (s_axis_tvalid),
        .i_addr_ready (s_axis_tready),
        .i_addr_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hits       (hits_seen),
        .o_misses     (misses_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: give up if the run stalls well beyond its slowest legal pace.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending);
            $display("set_assoc_cache_lru_lookup: mismatch");
            $finish;
        end
    end

    // Result side: stall in stretches of random style and length. Once the
    // stress phase asks for it, hold off for a long stretch so the block
    // backs up and has to drop s_axis_tready while addresses keep coming.
    initial begin : result_sink
        int          stretch_left;
        t_sink_style style;
        stretch_left = 0;
        style        = SINK_OPEN;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (stretch_left == 0) begin
                    style        = t_sink_style'($urandom_range(0, 3));
                    stretch_left = $urandom_range(4, 40);
                end
                stretch_left--;
                case (style)
                    SINK_OPEN:   m_axis_tready <= 1'b1;
                    SINK_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one address and hold it until the transfer. Keep tvalid high
    // inside a burst; at the end of a burst drop it for a random gap and
    // pick the next burst length, now and then a long gap-free stretch.
    task automatic issue_lookup(input logic [31:0] addr);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!s_axis_tready);
        lookups_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // Stop offering, let every outstanding result come back, then idle a
    // little longer so the block is quiet before the next register write.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write index_bits, then way_bits, on back-to-back cycles.
    task automatic program_geometry(input logic [3:0] index_data,
                                    input logic [3:0] way_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sacl_pkg::CFG_INDEX_BITS;
        i_cfg_data  <= index_data;
        @(posedge i_clk);
        i_cfg_index <= sacl_pkg::CFG_WAY_BITS;
        i_cfg_data  <= way_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random addresses mostly drawn from a tag pool a bit larger than the
    // associativity and a few hot sets, so hits, refills and evictions all
    // happen; the rest are scattered sets and fully random addresses.
    task automatic run_random_lookups(input int count, input int unsigned ib,
                                      input int unsigned wb);
        logic [31:0] tag_pool [17];
        logic [31:0] set_pool [4];
        logic [31:0] high_mask, set_no, addr;
        int          pool_size, pick, i, ways;
        ways      = 1 << wb;
        pool_size = ways + 1 + $urandom_range(0, ways);
        high_mask = 32'hFFFF_FFFF << (OFFSET_W + ib);
        for (i = 0; i < pool_size; i++)
            tag_pool[i] = $urandom & high_mask;
        for (i = 0; i < 4; i++)
            set_pool[i] = $urandom_range(0, (1 << ib) - 1);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                addr = $urandom;
            end else begin
                set_no = (pick < 15) ? $urandom_range(0, (1 << ib) - 1)
                                     : set_pool[$urandom_range(0, 3)];
                // Favor the first few tags so that reuse stays within reach.
                i = (pick < 55) ? $urandom_range(0, ways - 1)
                                : $urandom_range(0, pool_size - 1);
                addr = tag_pool[i] | (set_no << OFFSET_W) | $urandom_range(0, 63);
            end
            issue_lookup(addr);
        end
    endtask

    task automatic run_geometry(input logic [3:0] index_data, input logic [3:0] way_data,
                                input logic stress);
        int unsigned wb, ib;
        settle();
        program_geometry(index_data, way_data);
        geometries++;
        // Clamp as the block does so addresses land in the sets in use.
        wb = way_data[1:0];
        ib = (index_data > LINE_BITS - wb) ? LINE_BITS - wb : index_data;
        if (stress)
            hold_req <= 1'b1;
        run_random_lookups(RANDOM_PER_PHASE, ib, wb);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= sacl_pkg::CFG_INDEX_BITS;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: 4 sets of 4 ways, set in bits 7:6, tag above.
        issue_lookup(32'h0000_0000);   // cold miss, way 0
        issue_lookup(32'hFFFF_FFFF);   // all ones, cold miss in the top set
        issue_lookup(32'h0000_0000);   // hit
        issue_lookup(32'hFFFF_FFC0);   // hit, other end of the offset
        issue_lookup(32'h0000_0100);   // fill set 0, ways 1..3
        issue_lookup(32'h0000_0200);
        issue_lookup(32'h0000_0300);
        issue_lookup(32'h0000_013F);   // hit in the middle of the order
        issue_lookup(32'h0000_0400);   // full set: evict the oldest way
        issue_lookup(32'h0000_0000);   // evicted tag comes back as a miss
        issue_lookup(32'h0000_0300);   // hit after the reshuffle
        issue_lookup(32'h8000_0040);   // top tag bit alone
        issue_lookup(32'h7FFF_FFC0);
        issue_lookup(32'hAAAA_AAAA);
        issue_lookup(32'h5555_5555);
        run_random_lookups(RANDOM_PER_PHASE, 2, 2);

        run_geometry(4'd0,  4'd0,    1'b0);  // one set, one way
        run_geometry(4'd10, 4'd0,    1'b0);  // 1024 sets, direct mapped
        run_geometry(4'd0,  4'd3,    1'b0);  // one set, eight ways
        run_geometry(4'd7,  4'd3,    1'b1);  // largest legal shape, long hold-off
        run_geometry(4'd15, 4'hF,    1'b0);  // index too large for 8 ways
        run_geometry(4'd15, 4'd0,    1'b0);  // index clamped to 10
        run_geometry(4'd3,  4'd1,    1'b0);
        run_geometry(4'd5,  4'b0110, 1'b0);  // upper way_bits data ignored
        settle();

        $display("Covered %0d lookups over %0d cache geometries incl. clamped ones,",
                 lookups_sent, geometries);
        $display("%0d hits and %0d misses checked, with a long result-side stall.",
                 hits_seen, misses_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("set_assoc_cache_lru_lookup: match");
        end else begin
            $display("set_assoc_cache_lru_lookup: mismatch");
        end
        $finish;
    end

endmodule
